[hdl/plf_pkg.sv]
package plf_pkg;

  localparam int PIX_W             = 32;
  localparam int MANT_W            = PIX_W;
  localparam int LOG_FRACTION_BITS = 16;
  localparam int EXP_W             = $clog2(PIX_W + 1) + 0;
  localparam int SHIFT_W           = $clog2(MANT_W);
  localparam int LOG_W             = EXP_W + LOG_FRACTION_BITS;
  localparam int PROD_W            = LOG_W + PIX_W;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED  = CFG_IDX_W'(1);

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  localparam int BITS_8      = 8;
  localparam int BITS_16     = 16;
  localparam int BITS_32     = 32;
  localparam int LOG2_BITS_8  = 3;
  localparam int LOG2_BITS_16 = 4;
  localparam int LOG2_BITS_32 = 5;

  typedef struct packed {
    logic [1:0] width_code;
    logic       is_signed;
  } cfg_t;

  typedef struct packed {
    logic [MANT_W-1:0]            mant;
    logic [EXP_W-1:0]             expo;
    logic [LOG_FRACTION_BITS-1:0] frac;
  } log_data_t;

  function automatic logic [PIX_W-1:0] width_mask(input logic [1:0] code);
    logic [PIX_W-1:0] mask;
    unique case (code)
      WIDTH_8:  mask = PIX_W'((64'd1 << BITS_8) - 64'd1);
      WIDTH_16: mask = PIX_W'((64'd1 << BITS_16) - 64'd1);
      default:  mask = PIX_W'((64'd1 << BITS_32) - 64'd1);
    endcase
    return mask;
  endfunction

  function automatic logic [PIX_W-1:0] width_top(input logic [1:0] code);
    logic [PIX_W-1:0] top;
    unique case (code)
      WIDTH_8:  top = PIX_W'(64'd1 << (BITS_8 - 1));
      WIDTH_16: top = PIX_W'(64'd1 << (BITS_16 - 1));
      default:  top = PIX_W'(64'd1 << (BITS_32 - 1));
    endcase
    return top;
  endfunction

endpackage

[hdl/pixel_log_transform.sv]
// Logarithmic greyvalue transform, one pixel per transaction.
// The output is floor(M * log2(x + 1) / N) with M = 2^N - 1 and N = 8, 16 or 32.
// Input channel: a transaction is taken at each rising edge with start high and
// busy low. Busy is always low, so a new pixel may be offered in every cycle.
// Result channel: out_valid is high for exactly one cycle with out_pixel_out;
// the receiver takes it in that cycle and cannot hold it off.
// Configuration: cfg_we with cfg_index 0 writes the width code, index 1 the
// signed flag; other indexes are ignored. Write only while no pixel is in flight.
// Pipeline: a pixel taken on the input passes the normalizer (three stages),
// one squaring stage per fraction bit, each holding one 32 x 32 multiplier, and
// the final scaling stage before it appears on out_pixel_out. Throughput is one
// pixel per cycle.
// Reset: rst_n low at a rising edge empties the pipeline, drops every pixel in
// flight and returns the registers to 8-bit unsigned pixels.
module pixel_log_transform
  import plf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      in_pixel_in,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      accept;
  logic      sq_valid [0:LOG_FRACTION_BITS];
  log_data_t sq_data  [0:LOG_FRACTION_BITS];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH_CODE) begin
        cfg_r.width_code <= cfg_wdata[1:0];
      end else if (cfg_index == REG_IS_SIGNED) begin
        cfg_r.is_signed <= cfg_wdata[0];
      end
    end
  end

  plf_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .cfg       (cfg_r),
    .pixel     (in_pixel_in),
    .out_valid (sq_valid[0]),
    .out_data  (sq_data[0])
  );

  for (genvar i = 0; i < LOG_FRACTION_BITS; i++) begin : g_sq
    plf_sq_step u_sq_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[i]),
      .in_data   (sq_data[i]),
      .out_valid (sq_valid[i+1]),
      .out_data  (sq_data[i+1])
    );
  end

  plf_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid[LOG_FRACTION_BITS]),
    .in_data   (sq_data[LOG_FRACTION_BITS]),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_pixel (out_pixel_out)
  );

endmodule

[hdl/plf_norm.sv]
module plf_norm
  import plf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] pixel,
  output logic             out_valid,
  output log_data_t        out_data
);

  logic             v1_valid_r;
  logic [PIX_W:0]   v1_r;
  logic [PIX_W:0]   v1_nxt;
  logic             v2_valid_r;
  logic [PIX_W:0]   v2_r;
  logic [EXP_W-1:0] expo2_r;
  logic [EXP_W-1:0] expo2_nxt;
  logic             v3_valid_r;
  log_data_t        data3_r;
  log_data_t        data3_nxt;

  always_comb begin
    logic [PIX_W-1:0] u;
    u = pixel & width_mask(cfg.width_code);
    if (cfg.is_signed) begin
      u = u ^ width_top(cfg.width_code);
    end
    v1_nxt = {1'b0, u} + (PIX_W + 1)'(1);
  end

  always_comb begin
    expo2_nxt = '0;
    for (int k = 0; k <= PIX_W; k++) begin
      if (v1_r[k]) begin
        expo2_nxt = EXP_W'(k);
      end
    end
  end

  always_comb begin
    logic [SHIFT_W-1:0] sh;
    sh = SHIFT_W'(MANT_W - 1) - expo2_r[SHIFT_W-1:0];
    data3_nxt.expo = expo2_r;
    data3_nxt.frac = '0;
    if (expo2_r == EXP_W'(PIX_W)) begin
      data3_nxt.mant = MANT_W'(1) << (MANT_W - 1);
    end else begin
      data3_nxt.mant = v2_r[MANT_W-1:0] << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_valid_r <= 1'b0;
      v2_valid_r <= 1'b0;
      v3_valid_r <= 1'b0;
    end else begin
      v1_valid_r <= in_valid;
      v2_valid_r <= v1_valid_r;
      v3_valid_r <= v2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    v1_r    <= v1_nxt;
    v2_r    <= v1_r;
    expo2_r <= expo2_nxt;
    data3_r <= data3_nxt;
  end

  assign out_valid = v3_valid_r;
  assign out_data  = data3_r;

endmodule

[hdl/plf_sq_step.sv]
module plf_sq_step
  import plf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  log_data_t in_data,
  output logic      out_valid,
  output log_data_t out_data
);

  logic      valid_r;
  log_data_t data_r;
  log_data_t data_nxt;

  always_comb begin
    logic [2*MANT_W-1:0] sq;
    sq = {{MANT_W{1'b0}}, in_data.mant} * {{MANT_W{1'b0}}, in_data.mant};
    data_nxt.expo = in_data.expo;
    if (sq[2*MANT_W-1]) begin
      data_nxt.mant = sq[2*MANT_W-1:MANT_W];
      data_nxt.frac = {in_data.frac[LOG_FRACTION_BITS-2:0], 1'b1};
    end else begin
      data_nxt.mant = sq[2*MANT_W-2:MANT_W-1];
      data_nxt.frac = {in_data.frac[LOG_FRACTION_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[hdl/plf_scale.sv]
module plf_scale
  import plf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  log_data_t        in_data,
  input  cfg_t             cfg,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel
);

  logic             valid_r;
  logic [PIX_W-1:0] pixel_r;
  logic [PIX_W-1:0] pixel_nxt;

  always_comb begin
    logic [PROD_W-1:0] ext;
    logic [PROD_W-1:0] quot;
    logic [PIX_W-1:0]  mask;
    ext  = PROD_W'({in_data.expo, in_data.frac});
    mask = width_mask(cfg.width_code);
    unique case (cfg.width_code)
      WIDTH_8:  quot = ((ext << BITS_8) - ext) >> (LOG_FRACTION_BITS + LOG2_BITS_8);
      WIDTH_16: quot = ((ext << BITS_16) - ext) >> (LOG_FRACTION_BITS + LOG2_BITS_16);
      default:  quot = ((ext << BITS_32) - ext) >> (LOG_FRACTION_BITS + LOG2_BITS_32);
    endcase
    if (quot > PROD_W'(mask)) begin
      pixel_nxt = mask;
    end else begin
      pixel_nxt = quot[PIX_W-1:0];
    end
    if (cfg.is_signed) begin
      pixel_nxt = pixel_nxt ^ width_top(cfg.width_code);
    end
    pixel_nxt = pixel_nxt & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

endmodule
